// File: design/assert_macros.svh
// assertion macros shared by the scheduler rtl
// expects signals named clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pts_pkg.sv
// shared constants and codes for the priority task scheduler
// no dependencies
package pts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TICK_BITS_DEF = 32;

  localparam int ACT_W      = 3;
  localparam int TIDX_W     = 4;
  localparam int PRIO_W     = 8;
  localparam int TICK_IN_W  = 32;
  localparam int RS_W       = 2;
  localparam int ACTIVE_W   = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd1;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_ACTIVE_TASKS = 1'b0;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_YIELD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SLEEP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWITCH = 3'd4;

  typedef logic [RS_W-1:0] run_state_t;
  localparam run_state_t RS_WAITING = 2'd0;
  localparam run_state_t RS_READY   = 2'd1;
  localparam run_state_t RS_RUNNING = 2'd2;

endpackage

// File: design/pts_in_if.sv
// input channel of the scheduler: valid/ready plus one action
// depends on pts_pkg
interface pts_in_if;
  logic                         valid;
  logic                         ready;
  logic [pts_pkg::ACT_W-1:0]    action;
  logic [pts_pkg::TIDX_W-1:0]   task_index;
  logic [pts_pkg::PRIO_W-1:0]   task_priority;
  logic [pts_pkg::TICK_IN_W-1:0] now_tick;
  logic [pts_pkg::TICK_IN_W-1:0] sleep_ticks;

  modport source (output valid, action, task_index, task_priority, now_tick, sleep_ticks,
                  input ready);
  modport sink (input valid, action, task_index, task_priority, now_tick, sleep_ticks,
                output ready);
endinterface

// File: design/pts_out_if.sv
// result channel of the scheduler: valid/ready plus one result
// depends on pts_pkg
interface pts_out_if;
  logic                       valid;
  logic                       ready;
  logic                       switch_requested;
  logic                       yielded;
  logic [pts_pkg::TIDX_W-1:0] outgoing_task;
  logic [pts_pkg::TIDX_W-1:0] incoming_task;
  logic [pts_pkg::TIDX_W-1:0] nominated_task;

  modport source (output valid, switch_requested, yielded, outgoing_task, incoming_task,
                  nominated_task, input ready);
  modport sink (input valid, switch_requested, yielded, outgoing_task, incoming_task,
                nominated_task, output ready);
endinterface

// File: design/pts_task_mem.sv
// task table memory: priority, run state and wake tick per entry
// one write port, one registered read port, per-entry valid bits; depends on pts_pkg
module pts_task_mem #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [pts_pkg::PRIO_W-1:0]  wr_prio,
  input  pts_pkg::run_state_t         wr_rs,
  input  logic [TICK_BITS-1:0]        wr_wake,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [pts_pkg::PRIO_W-1:0]  rd_prio,
  output pts_pkg::run_state_t         rd_rs,
  output logic [TICK_BITS-1:0]        rd_wake
);

  localparam int WORD_W = pts_pkg::PRIO_W + pts_pkg::RS_W + TICK_BITS;

  logic [WORD_W-1:0]    mem_r [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_r;
  logic [WORD_W-1:0]    rd_word_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_prio, wr_rs, wr_wake};
    end
    if (rd_en) begin
      rd_word_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // unwritten entries read as the reset contents
  assign rd_prio = rd_valid_r ? rd_word_r[WORD_W-1 -: pts_pkg::PRIO_W] : '0;
  assign rd_rs   = rd_valid_r ? rd_word_r[TICK_BITS +: pts_pkg::RS_W] : pts_pkg::RS_WAITING;
  assign rd_wake = rd_valid_r ? rd_word_r[TICK_BITS-1:0] : '1;

endmodule

// File: design/priority_task_scheduler_core.sv
// priority task scheduler, top level
// depends on pts_pkg, pts_in_if, pts_out_if, pts_task_mem and assert_macros.svh
//
// usage:
//   in_ch carries one action per transaction (load, tick, yield, sleep, switch);
//   out_ch returns exactly one result transaction per action, in order.
//   cfg_* is an apb-style port; register 0 (byte address 0) is active_tasks.
//   write configuration only while no action is in flight.
// timing, n = min(active_tasks, MAX_TASKS):
//   load writes one entry; unused actions go straight to the result. switch reads
//   the outgoing entry, then the incoming one. tick and yield scan one entry per
//   cycle through the single read port, entries 0 to n-1. sleep writes the
//   sleeping entry, then scans entries 1 and up.
//   one action at a time; in_ch.ready rises in the same cycle as the result
//   valid, once the result is loaded into the output register.
// reset:
//   all entries read as priority 0, waiting, wake tick never; current and next
//   task are 0; active_tasks is 1. no clearing pass is needed.
// stall: the result waits in the output register; the next action is accepted
//   meanwhile and its result is held until the output register frees.
`include "assert_macros.svh"

module priority_task_scheduler_core #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pts_in_if.sink                            in_ch,
  pts_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pts_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [pts_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LOAD     = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_SLEEP_WR = 8'b0000_1000,
    S_SW_RD    = 8'b0001_0000,
    S_SW_CUR   = 8'b0010_0000,
    S_SW_NXT   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pts_pkg::ACT_W-1:0]       act_r, act_nxt;
  logic [pts_pkg::TIDX_W-1:0]      tidx_r, tidx_nxt;
  logic [pts_pkg::PRIO_W-1:0]      prio_r, prio_nxt;
  logic [TICK_BITS-1:0]            now_r, now_nxt;
  logic [TICK_BITS-1:0]            slp_r, slp_nxt;
  logic [pts_pkg::ACTIVE_W-1:0]    active_r, active_nxt;
  logic [IDX_W-1:0]                cur_r, cur_nxt;
  logic [IDX_W-1:0]                next_r, next_nxt;
  logic [pts_pkg::PRIO_W-1:0]      cur_prio_r, cur_prio_nxt;
  logic [pts_pkg::PRIO_W-1:0]      nxt_prio_r, nxt_prio_nxt;
  logic [pts_pkg::PRIO_W-1:0]      prio0_r, prio0_nxt;
  logic                            sw_r, sw_nxt;
  logic                            yl_r, yl_nxt;
  logic [IDX_W-1:0]                outg_r, outg_nxt;
  logic [IDX_W-1:0]                inc_r, inc_nxt;
  logic [CNT_W-1:0]                rd_p_r, rd_p_nxt;
  logic                            dv_r, dv_nxt;
  logic [IDX_W-1:0]                dp_r, dp_nxt;
  logic                            found_r, found_nxt;
  logic [IDX_W-1:0]                fnd_idx_r, fnd_idx_nxt;
  logic [pts_pkg::PRIO_W-1:0]      fnd_prio_r, fnd_prio_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_sw_r, out_sw_nxt;
  logic                            out_yl_r, out_yl_nxt;
  logic [pts_pkg::TIDX_W-1:0]      out_outg_r, out_outg_nxt;
  logic [pts_pkg::TIDX_W-1:0]      out_inc_r, out_inc_nxt;
  logic [pts_pkg::TIDX_W-1:0]      out_nom_r, out_nom_nxt;

  logic                            mem_wr_en;
  logic [IDX_W-1:0]                mem_wr_addr;
  logic [pts_pkg::PRIO_W-1:0]      mem_wr_prio;
  pts_pkg::run_state_t             mem_wr_rs;
  logic [TICK_BITS-1:0]            mem_wr_wake;
  logic                            mem_rd_en;
  logic [IDX_W-1:0]                mem_rd_addr;
  logic [pts_pkg::PRIO_W-1:0]      mem_rd_prio;
  pts_pkg::run_state_t             mem_rd_rs;
  logic [TICK_BITS-1:0]            mem_rd_wake;

  logic [CNT_W-1:0]                n_used;
  logic                            cfg_wr;
  logic                            cfg_hit;
  logic                            scan_more;

  pts_task_mem #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_BITS (TICK_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_prio (mem_wr_prio),
    .wr_rs   (mem_wr_rs),
    .wr_wake (mem_wr_wake),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_prio (mem_rd_prio),
    .rd_rs   (mem_rd_rs),
    .rd_wake (mem_rd_wake)
  );

  assign n_used = (32'(active_r) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(active_r);
  assign scan_more = (rd_p_r < n_used);

  assign cfg_hit    = (cfg_paddr[pts_pkg::CFG_ADDR_W-1:2] == pts_pkg::REG_ACTIVE_TASKS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? pts_pkg::CFG_DATA_W'(active_r) : '0;

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.switch_requested = out_sw_r;
  assign out_ch.yielded          = out_yl_r;
  assign out_ch.outgoing_task    = out_outg_r;
  assign out_ch.incoming_task    = out_inc_r;
  assign out_ch.nominated_task   = out_nom_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    tidx_nxt      = tidx_r;
    prio_nxt      = prio_r;
    now_nxt       = now_r;
    slp_nxt       = slp_r;
    active_nxt    = active_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    cur_prio_nxt  = cur_prio_r;
    nxt_prio_nxt  = nxt_prio_r;
    prio0_nxt     = prio0_r;
    sw_nxt        = sw_r;
    yl_nxt        = yl_r;
    outg_nxt      = outg_r;
    inc_nxt       = inc_r;
    rd_p_nxt      = rd_p_r;
    dv_nxt        = dv_r;
    dp_nxt        = dp_r;
    found_nxt     = found_r;
    fnd_idx_nxt   = fnd_idx_r;
    fnd_prio_nxt  = fnd_prio_r;
    out_valid_nxt = out_valid_r;
    out_sw_nxt    = out_sw_r;
    out_yl_nxt    = out_yl_r;
    out_outg_nxt  = out_outg_r;
    out_inc_nxt   = out_inc_r;
    out_nom_nxt   = out_nom_r;

    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_prio = prio_r;
    mem_wr_rs   = pts_pkg::RS_READY;
    mem_wr_wake = '1;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;

    if (cfg_wr && cfg_hit) begin
      active_nxt = cfg_pwdata[pts_pkg::ACTIVE_W-1:0];
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = in_ch.action;
          tidx_nxt  = in_ch.task_index;
          prio_nxt  = in_ch.task_priority;
          now_nxt   = TICK_BITS'(in_ch.now_tick);
          slp_nxt   = TICK_BITS'(in_ch.sleep_ticks);
          sw_nxt    = 1'b0;
          yl_nxt    = 1'b0;
          outg_nxt  = '0;
          inc_nxt   = '0;
          dv_nxt    = 1'b0;
          found_nxt = 1'b0;
          rd_p_nxt  = '0;
          case (in_ch.action)
            pts_pkg::ACT_LOAD:   state_nxt = S_LOAD;
            pts_pkg::ACT_TICK:   state_nxt = S_SCAN;
            pts_pkg::ACT_YIELD:  state_nxt = S_SCAN;
            pts_pkg::ACT_SLEEP:  state_nxt = S_SLEEP_WR;
            pts_pkg::ACT_SWITCH: state_nxt = S_SW_RD;
            default:             state_nxt = S_DONE;
          endcase
        end
      end

      S_LOAD: begin
        if (32'(tidx_r) < MAX_TASKS) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = IDX_W'(tidx_r);
          mem_wr_prio = prio_r;
          mem_wr_rs   = pts_pkg::RS_READY;
          mem_wr_wake = '1;
          if (32'(tidx_r) == 32'(cur_r)) begin
            cur_prio_nxt = prio_r;
          end
          if (32'(tidx_r) == 32'(next_r)) begin
            nxt_prio_nxt = prio_r;
          end
          if (tidx_r == '0) begin
            prio0_nxt = prio_r;
          end
        end
        state_nxt = S_DONE;
      end

      S_SLEEP_WR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = cur_r;
        mem_wr_prio  = cur_prio_r;
        mem_wr_rs    = pts_pkg::RS_WAITING;
        mem_wr_wake  = now_r + slp_r;
        fnd_idx_nxt  = '0;
        fnd_prio_nxt = prio0_r;
        rd_p_nxt     = CNT_W'(1);
        state_nxt    = S_SCAN;
      end

      S_SCAN: begin
        // read issue runs one entry ahead of the update
        if (scan_more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_p_r[IDX_W-1:0];
          rd_p_nxt    = CNT_W'(rd_p_r + CNT_W'(1));
          dv_nxt      = 1'b1;
          dp_nxt      = rd_p_r[IDX_W-1:0];
        end else begin
          dv_nxt = 1'b0;
        end

        if (dv_r) begin
          case (act_r)
            pts_pkg::ACT_TICK: begin
              if (mem_rd_wake <= now_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = dp_r;
                mem_wr_prio = mem_rd_prio;
                mem_wr_rs   = pts_pkg::RS_READY;
                mem_wr_wake = '1;
                if (cur_prio_r < mem_rd_prio) begin
                  sw_nxt = 1'b1;
                  if (nxt_prio_r < mem_rd_prio) begin
                    next_nxt     = dp_r;
                    nxt_prio_nxt = mem_rd_prio;
                  end
                end
              end
            end
            pts_pkg::ACT_YIELD: begin
              if (!found_r && (cur_prio_r <= mem_rd_prio)
                  && (mem_rd_rs != pts_pkg::RS_WAITING) && (dp_r != cur_r)) begin
                found_nxt = 1'b1;
                sw_nxt    = 1'b1;
                yl_nxt    = 1'b1;
                if (nxt_prio_r < mem_rd_prio) begin
                  next_nxt     = dp_r;
                  nxt_prio_nxt = mem_rd_prio;
                end
              end
            end
            pts_pkg::ACT_SLEEP: begin
              if ((mem_rd_rs == pts_pkg::RS_READY) && (fnd_prio_r < mem_rd_prio)) begin
                fnd_idx_nxt  = dp_r;
                fnd_prio_nxt = mem_rd_prio;
              end
            end
            default: begin
            end
          endcase
        end

        if (!scan_more && !dv_r) begin
          if (act_r == pts_pkg::ACT_SLEEP) begin
            sw_nxt = 1'b1;
            if (nxt_prio_r < fnd_prio_r) begin
              next_nxt     = fnd_idx_r;
              nxt_prio_nxt = fnd_prio_r;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_SW_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cur_r;
        outg_nxt    = cur_r;
        inc_nxt     = next_r;
        state_nxt   = S_SW_CUR;
      end

      S_SW_CUR: begin
        // a task switched to itself is written once, as running
        if ((mem_rd_rs == pts_pkg::RS_RUNNING) && (cur_r != next_r)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cur_r;
          mem_wr_prio = mem_rd_prio;
          mem_wr_rs   = pts_pkg::RS_READY;
          mem_wr_wake = mem_rd_wake;
        end
        mem_rd_en   = 1'b1;
        mem_rd_addr = next_r;
        state_nxt   = S_SW_NXT;
      end

      S_SW_NXT: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = next_r;
        mem_wr_prio  = mem_rd_prio;
        mem_wr_rs    = pts_pkg::RS_RUNNING;
        mem_wr_wake  = mem_rd_wake;
        cur_nxt      = next_r;
        cur_prio_nxt = nxt_prio_r;
        next_nxt     = '0;
        nxt_prio_nxt = prio0_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sw_nxt    = sw_r;
          out_yl_nxt    = yl_r;
          out_outg_nxt  = pts_pkg::TIDX_W'(outg_r);
          out_inc_nxt   = pts_pkg::TIDX_W'(inc_r);
          out_nom_nxt   = pts_pkg::TIDX_W'(next_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= pts_pkg::ACTIVE_RESET;
      cur_r       <= '0;
      next_r      <= '0;
      cur_prio_r  <= '0;
      nxt_prio_r  <= '0;
      prio0_r     <= '0;
      rd_p_r      <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      cur_r       <= cur_nxt;
      next_r      <= next_nxt;
      cur_prio_r  <= cur_prio_nxt;
      nxt_prio_r  <= nxt_prio_nxt;
      prio0_r     <= prio0_nxt;
      rd_p_r      <= rd_p_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    tidx_r     <= tidx_nxt;
    prio_r     <= prio_nxt;
    now_r      <= now_nxt;
    slp_r      <= slp_nxt;
    sw_r       <= sw_nxt;
    yl_r       <= yl_nxt;
    outg_r     <= outg_nxt;
    inc_r      <= inc_nxt;
    dp_r       <= dp_nxt;
    fnd_idx_r  <= fnd_idx_nxt;
    fnd_prio_r <= fnd_prio_nxt;
    out_sw_r   <= out_sw_nxt;
    out_yl_r   <= out_yl_nxt;
    out_outg_r <= out_outg_nxt;
    out_inc_r  <= out_inc_nxt;
    out_nom_r  <= out_nom_nxt;
  end

  `PTS_ASSERT(a_no_rw_clash, (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr), "table read and write hit the same entry")
  `PTS_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result raised outside the done state")
  `PTS_ASSERT(a_switch_update, $past(state_r == S_SW_NXT) |-> (next_r == '0 && cur_r == $past(next_r)), "switch did not hand over the nominated task")
  `PTS_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid_r && state_r == S_IDLE), "reset left the block busy")

endmodule

// File: verif/priority_task_scheduler_core_test.sv
`timescale 1ns / 100ps
// self-checking testbench for priority_task_scheduler_core: directed table then random actions
// depends on pts_pkg, pts_in_if, pts_out_if and the scheduler rtl
module priority_task_scheduler_core_test;
  import pts_pkg::*;

  localparam int TASKS            = MAX_TASKS_DEF;
  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = 30;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int MAX_REPORTS      = 10;

  localparam logic [ACT_W-1:0]      ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0]      ACT_SPARE_HI = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] ACTIVE_ADDR  = {REG_ACTIVE_TASKS, 2'b00};

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [TIDX_W-1:0]    idx;
    logic [PRIO_W-1:0]    prio;
    logic [TICK_IN_W-1:0] now;
    logic [TICK_IN_W-1:0] slp;
  } sched_action_t;

  typedef struct packed {
    logic              switch_requested;
    logic              yielded;
    logic [TIDX_W-1:0] outgoing_task;
    logic [TIDX_W-1:0] incoming_task;
    logic [TIDX_W-1:0] nominated_task;
  } sched_result_t;

  typedef enum logic {ROW_ACTION, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [ACTIVE_W-1:0]  cfg_val;
    logic [ACT_W-1:0]     action;
    logic [TIDX_W-1:0]    idx;
    logic [PRIO_W-1:0]    prio;
    logic [TICK_IN_W-1:0] now;
    logic [TICK_IN_W-1:0] slp;
    logic                 typed;
    sched_result_t        res;
  } script_row_t;

  localparam logic          TYPED     = 1'b1;
  localparam logic          PREDICTED = 1'b0;
  localparam sched_result_t ZERO_RES  = '0;
  localparam logic [31:0]   ONES      = 32'hFFFF_FFFF;

  localparam int DIR_ROWS = 29;
  localparam script_row_t DIR_SCRIPT [DIR_ROWS] = '{
    // switch and spare action straight out of reset, load above the active range
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, TYPED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SPARE_HI, 4'hF,  8'hFF,  ONES,          ONES,  TYPED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_LOAD,     4'd15, 8'd255, 32'd0,         32'd0, TYPED, ZERO_RES},
    '{ROW_CONFIG, 5'd16, ACT_LOAD,     4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_LOAD,     4'd1,  8'd10,  32'd0,         32'd0, TYPED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_LOAD,     4'd2,  8'd10,  32'd0,         32'd0, TYPED, ZERO_RES},
    // tick at the all-ones count wakes everything, equal priority does not replace
    '{ROW_ACTION, 5'd0,  ACT_TICK,     4'd0,  8'd0,   ONES,          32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_YIELD,    4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_LOAD,     4'd3,  8'd255, 32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_YIELD,    4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    // wake tick wraps around
    '{ROW_ACTION, 5'd0,  ACT_SLEEP,    4'd0,  8'd0,   32'hFFFF_FFF0, 32'h20, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_TICK,     4'd0,  8'd0,   32'h0F,        32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_TICK,     4'd0,  8'd0,   32'h10,        32'd0, PREDICTED, ZERO_RES},
    // reload of the running task, then switch of a task to itself
    '{ROW_ACTION, 5'd0,  ACT_LOAD,     4'd15, 8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SLEEP,    4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    // no entries in use
    '{ROW_CONFIG, 5'd0,  ACT_LOAD,     4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_TICK,     4'd0,  8'd0,   ONES,          32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SLEEP,    4'd0,  8'd0,   32'd5,         32'd7, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_YIELD,    4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SPARE_LO, 4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    // register above the table size
    '{ROW_CONFIG, 5'd31, ACT_LOAD,     4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_TICK,     4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SLEEP,    4'd0,  8'd0,   ONES,          ONES,  PREDICTED, ZERO_RES},
    '{ROW_ACTION, 5'd0,  ACT_SWITCH,   4'd0,  8'd0,   32'd0,         32'd0, PREDICTED, ZERO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  priority_task_scheduler_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // scheduler state as predicted
  logic [PRIO_W-1:0]    prio_of  [TASKS];
  run_state_t           state_of [TASKS];
  logic [TICK_IN_W-1:0] wake_of  [TASKS];
  logic [TIDX_W-1:0]    running_task;
  logic [TIDX_W-1:0]    nominee;
  logic [ACTIVE_W-1:0]  active_tasks_now;

  sched_result_t pending_results [$];
  int unsigned   error_count = 0;
  int unsigned   src_idle_pct;
  int unsigned   snk_idle_pct;
  bit            hold_off_req = 1'b0;
  int unsigned   quiet_cycles = 0;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  function automatic void offer_candidate(logic [TIDX_W-1:0] cand);
    if (prio_of[nominee] < prio_of[cand])
      nominee = cand;
  endfunction

  function automatic sched_result_t schedule_step(sched_action_t a);
    sched_result_t r;
    int unsigned   n;
    int unsigned   p;
    int unsigned   best;
    r = '0;
    n = (active_tasks_now > TASKS) ? TASKS : active_tasks_now;
    case (a.action)
      ACT_LOAD: begin
        prio_of[a.idx]  = a.prio;
        state_of[a.idx] = RS_READY;
        wake_of[a.idx]  = '1;
      end
      ACT_TICK: begin
        for (p = 0; p < n; p++) begin
          if (wake_of[p] <= a.now) begin
            wake_of[p]  = '1;
            state_of[p] = RS_READY;
            if (prio_of[running_task] < prio_of[p]) begin
              offer_candidate(p[TIDX_W-1:0]);
              r.switch_requested = 1'b1;
            end
          end
        end
      end
      ACT_YIELD: begin
        for (p = 0; p < n; p++) begin
          if (prio_of[running_task] <= prio_of[p] && state_of[p] >= RS_READY &&
              p != running_task) begin
            offer_candidate(p[TIDX_W-1:0]);
            r.switch_requested = 1'b1;
            r.yielded          = 1'b1;
            break;
          end
        end
      end
      ACT_SLEEP: begin
        wake_of[running_task]  = a.now + a.slp;
        state_of[running_task] = RS_WAITING;
        best = 0;
        for (p = 1; p < n; p++) begin
          if (state_of[p] == RS_READY && prio_of[best] < prio_of[p])
            best = p;
        end
        if (best >= n || state_of[best] < RS_READY)
          best = 0;
        offer_candidate(best[TIDX_W-1:0]);
        r.switch_requested = 1'b1;
      end
      ACT_SWITCH: begin
        r.outgoing_task = running_task;
        r.incoming_task = nominee;
        if (state_of[running_task] == RS_RUNNING)
          state_of[running_task] = RS_READY;
        state_of[nominee] = RS_RUNNING;
        running_task      = nominee;
        nominee           = '0;
      end
      default: ;
    endcase
    r.nominated_task = nominee;
    return r;
  endfunction

  task automatic issue_action(input sched_action_t a, input logic use_typed,
                              input sched_result_t typed_res);
    sched_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= a.action;
    in_ch.task_index    <= a.idx;
    in_ch.task_priority <= a.prio;
    in_ch.now_tick      <= a.now;
    in_ch.sleep_ticks   <= a.slp;
    do @(posedge clk); while (!in_ch.ready);
    predicted = schedule_step(a);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_tasks(input logic [ACTIVE_W-1:0] val);
    logic [CFG_DATA_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ACTIVE_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    active_tasks_now = val;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field("active_tasks readback", 32'(val), readback);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result transaction with no expectation waiting");
      end else begin
        want = pending_results.pop_front();
        check_field("switch_requested", 32'(want.switch_requested), 32'(out_ch.switch_requested));
        check_field("yielded", 32'(want.yielded), 32'(out_ch.yielded));
        check_field("outgoing_task", 32'(want.outgoing_task), 32'(out_ch.outgoing_task));
        check_field("incoming_task", 32'(want.incoming_task), 32'(out_ch.incoming_task));
        check_field("nominated_task", 32'(want.nominated_task), 32'(out_ch.nominated_task));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sched_action_t       act;
    script_row_t         row;
    logic [ACTIVE_W-1:0] phase_cfg;
    logic [TICK_IN_W-1:0] tick_now;
    int unsigned         pick;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_LOAD;
    in_ch.task_index    = '0;
    in_ch.task_priority = '0;
    in_ch.now_tick      = '0;
    in_ch.sleep_ticks   = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    for (int t = 0; t < TASKS; t++) begin
      prio_of[t]  = '0;
      state_of[t] = RS_WAITING;
      wake_of[t]  = '1;
    end
    running_task     = '0;
    nominee          = '0;
    active_tasks_now = ACTIVE_RESET;
    src_idle_pct     = 34;
    snk_idle_pct     = 78;
    tick_now         = $urandom;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_SCRIPT[r];
      if (row.kind == ROW_CONFIG) begin
        settle_idle();
        write_active_tasks(row.cfg_val);
      end else begin
        act = '{row.action, row.idx, row.prio, row.now, row.slp};
        issue_action(act, row.typed, row.res);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      settle_idle();
      case (phase)
        0: begin
          phase_cfg    = 5'd16;
          src_idle_pct = 34;
          snk_idle_pct = 78;
        end
        1: begin
          phase_cfg    = ACTIVE_W'($urandom_range(15, 2));
          src_idle_pct = 78;
          snk_idle_pct = 34;
        end
        2: begin
          phase_cfg    = 5'd31;
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        default: begin
          phase_cfg    = ACTIVE_W'($urandom_range(6, 1));
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_active_tasks(phase_cfg);
      if (phase == 2)
        hold_off_req = 1'b1;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        pick     = $urandom_range(99);
        act.idx  = TIDX_W'($urandom_range(15, 0));
        act.prio = ($urandom_range(1, 0) != 0) ? PRIO_W'($urandom_range(7, 0))
                                               : PRIO_W'($urandom);
        if ($urandom_range(99) < 8)
          tick_now = $urandom;
        else
          tick_now = tick_now + $urandom_range(8, 0);
        act.now = tick_now;
        act.slp = ($urandom_range(99) < 15) ? $urandom : TICK_IN_W'($urandom_range(12, 0));
        if (pick < 22)
          act.action = ACT_LOAD;
        else if (pick < 45)
          act.action = ACT_TICK;
        else if (pick < 60)
          act.action = ACT_YIELD;
        else if (pick < 78)
          act.action = ACT_SLEEP;
        else if (pick < 96)
          act.action = ACT_SWITCH;
        else
          act.action = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        issue_action(act, PREDICTED, ZERO_RES);
      end
    end

    settle_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
